// ===== design/cubic_bezier_easing_eval_core_assert.svh =====
// Assertion macros shared by the easing core RTL.
`ifndef CUBIC_BEZIER_EASING_EVAL_CORE_ASSERT_SVH
`define CUBIC_BEZIER_EASING_EVAL_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define CBE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define CBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cbe_pkg.sv =====
// Shared constants and sequencer state type for the cubic Bezier easing core.
package cbe_pkg;

    localparam int DEF_MAX_ITERATIONS = 12;
    localparam int DEF_FRAC_BITS      = 16;

    localparam int FIELD_W     = 17;
    localparam int STEPS_W     = 4;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - FIELD_W - STEPS_W;

    localparam logic [FIELD_W-1:0] Q16_ONE   = 17'h10000;
    localparam logic [STEPS_W-1:0] STEPS_SAT = 4'hF;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_SETUP = 18'h00002,
        S_M1    = 18'h00004,
        S_A1    = 18'h00008,
        S_M2    = 18'h00010,
        S_A2    = 18'h00020,
        S_M3    = 18'h00040,
        S_A3    = 18'h00080,
        S_UPD   = 18'h00100,
        S_F0    = 18'h00200,
        S_F1    = 18'h00400,
        S_F2    = 18'h00800,
        S_F3    = 18'h01000,
        S_F4    = 18'h02000,
        S_F5    = 18'h04000,
        S_F6    = 18'h08000,
        S_F7    = 18'h10000,
        S_DONE  = 18'h20000
    } t_state;

endpackage

// ===== design/cubic_bezier_easing_eval_core.sv =====
// Cubic Bezier easing core: maps progress x through the curve to an eased y.
// One item is worked at a time through a single shared multiplier. Diagonal
// control points go from setup straight to the result. Otherwise the core
// runs residual evaluations, steps_taken + 1 of them on convergence, else
// MAX_ITERATIONS: each evaluation is a three-step Horner chain on the
// multiplier, every step waiting for its registered product, plus an update
// state; setup comes before them and the final y polynomial after. The core
// takes the next input in the cycle after the result is loaded; a held result
// does not block a new input, only the next load.
`include "cubic_bezier_easing_eval_core_assert.svh"

module cubic_bezier_easing_eval_core #(
    parameter int MAX_ITERATIONS = cbe_pkg::DEF_MAX_ITERATIONS,
    parameter int FRAC_BITS      = cbe_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_progress[16:0], cp1_x[33:17], cp1_y[50:34], cp2_x[67:51], cp2_y[84:68]
    input  logic [cbe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // y_value[16:0], steps_taken[20:17]
    output logic [cbe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // converged[0]
    output logic                               m_axis_tuser
);

    localparam int FW    = cbe_pkg::FIELD_W;
    localparam int W     = FRAC_BITS + 5;
    localparam int XW    = W + 4;
    localparam int SW    = $clog2(MAX_ITERATIONS + 1);
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int EPS_I = (ONE_I * 5 + 5000) / 10000;
    localparam int SHL   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int XI    = FW + SHL;
    localparam int YW    = FRAC_BITS + 1;
    localparam int DN    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int UP    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int RND   = (DN > 0) ? (1 << (DN - 1)) : 0;
    localparam int QW    = YW + UP + 1;

    localparam logic signed [W-1:0] Q_TOP  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Q_BOT  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] Q_ONE  = W'(ONE_I);
    localparam logic signed [W-1:0] Q_EPS  = W'(EPS_I);
    localparam logic signed [W-1:0] Q_NEPS = -Q_EPS;

    function automatic logic signed [XW-1:0] ext4(input logic signed [W-1:0] v);
        return {{4{v[W-1]}}, v};
    endfunction

    function automatic logic signed [XW-1:0] x3(input logic signed [XW-1:0] v);
        return (v <<< 1) + v;
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        logic [4:0] hi;
        hi = v[XW-1:W-1];
        if ((&hi) || !(|hi)) begin
            return v[W-1:0];
        end
        return v[XW-1] ? Q_BOT : Q_TOP;
    endfunction

    function automatic logic signed [W-1:0] to_int(input logic [FW-1:0] raw);
        logic [XI-1:0] e;
        e = XI'(raw) << SHL;
        e = e >> SHR;
        return W'(e);
    endfunction

    cbe_pkg::t_state r_state, n_state;

    logic [FW-1:0] r_x_raw, r_c1x_raw, r_c1y_raw, r_c2x_raw, r_c2y_raw;
    logic signed [W-1:0] r_x, r_ay, r_by, r_k0, r_k1, r_k2, r_t, r_f;
    logic signed [W-1:0] r_r, r_t3x, r_t2, r_rr, r_s2, r_t3, r_v, r_u, r_m1;
    logic [YW-1:0]       r_y;
    logic [SW-1:0]       r_steps;
    logic                r_conv, r_diag;

    logic                        r_o_valid;
    logic [FW-1:0]               r_o_y;
    logic [cbe_pkg::STEPS_W-1:0] r_o_steps;
    logic                        r_o_conv;

    logic signed [W-1:0] mul_a, mul_b, w_p;

    logic                in_xfer, out_load, diag, f_ok, last_step, steps_live;
    logic signed [W-1:0] a_int, b_int;
    logic signed [W-1:0] k0_new, k1_new, k2_new;
    logic signed [W-1:0] f_add_k1, f_add_k2, f_sub_x, t_upd;
    logic signed [W-1:0] r_new, t3x_new, s2_new;
    logic signed [XW-1:0] y_sum;
    logic [YW-1:0]       y_clamp;
    logic [SW-1:0]       steps_inc;
    logic [QW-1:0]       yq;
    logic [FW-1:0]       y_out;
    logic [SW+3:0]       steps_ext;
    logic [cbe_pkg::STEPS_W-1:0] steps_out;

    cbe_mul_q #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (w_p)
    );

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == cbe_pkg::S_DONE) && (!r_o_valid || m_axis_tready);
    // step count is loaded in setup, so it is meaningful from the first solve state on
    assign steps_live = (r_state != cbe_pkg::S_IDLE) && (r_state != cbe_pkg::S_SETUP);

    always_comb begin
        diag   = (r_c1x_raw == r_c1y_raw) && (r_c2x_raw == r_c2y_raw);
        a_int  = to_int(r_c1x_raw);
        b_int  = to_int(r_c2x_raw);
        k0_new = sat_w(ext4(Q_ONE) + x3(ext4(a_int)) - x3(ext4(b_int)));
        k1_new = sat_w(x3(ext4(b_int)) - (x3(ext4(a_int)) <<< 1));
        k2_new = sat_w(x3(ext4(a_int)));

        f_add_k1 = sat_w(ext4(w_p) + ext4(r_k1));
        f_add_k2 = sat_w(ext4(w_p) + ext4(r_k2));
        f_sub_x  = sat_w(ext4(w_p) - ext4(r_x));
        f_ok     = (r_f <= Q_EPS) && (r_f >= Q_NEPS);
        t_upd    = sat_w(ext4(r_t) - ext4(r_f >>> 1));

        steps_inc = r_steps + SW'(1);
        last_step = (steps_inc == SW'(MAX_ITERATIONS));

        r_new   = sat_w(ext4(Q_ONE) - ext4(r_t));
        t3x_new = sat_w(x3(ext4(r_t)));
        s2_new  = sat_w(x3(ext4(r_t2)));

        // t^3 + m1 + m2, the last product straight off the multiplier
        y_sum = ext4(r_t3) + ext4(r_m1) + ext4(w_p);
        if (y_sum[XW-1]) begin
            y_clamp = '0;
        end else if (y_sum > ext4(Q_ONE)) begin
            y_clamp = YW'(ONE_I);
        end else begin
            y_clamp = y_sum[YW-1:0];
        end

        yq = ((QW'(r_y) + QW'(RND)) >> DN) << UP;
        if (r_diag) begin
            y_out = (r_x_raw > cbe_pkg::Q16_ONE) ? cbe_pkg::Q16_ONE : r_x_raw;
        end else begin
            y_out = yq[FW-1:0];
        end

        steps_ext = (SW+4)'(r_steps);
        steps_out = (steps_ext > (SW+4)'(cbe_pkg::STEPS_SAT)) ? cbe_pkg::STEPS_SAT
                                                              : steps_ext[3:0];
    end

    // operand select for the shared multiplier; product lands in the next cycle
    always_comb begin
        case (r_state)
            cbe_pkg::S_M1: begin
                mul_a = r_k0;
                mul_b = r_t;
            end
            cbe_pkg::S_M2, cbe_pkg::S_M3: begin
                mul_a = r_f;
                mul_b = r_t;
            end
            cbe_pkg::S_F0: begin
                mul_a = r_t;
                mul_b = r_t;
            end
            cbe_pkg::S_F1: begin
                mul_a = r_r;
                mul_b = r_r;
            end
            cbe_pkg::S_F2: begin
                mul_a = r_t2;
                mul_b = r_t;
            end
            cbe_pkg::S_F3: begin
                mul_a = r_t3x;
                mul_b = r_rr;
            end
            cbe_pkg::S_F4: begin
                mul_a = r_s2;
                mul_b = r_r;
            end
            cbe_pkg::S_F5: begin
                mul_a = r_v;
                mul_b = r_ay;
            end
            cbe_pkg::S_F6: begin
                mul_a = r_u;
                mul_b = r_by;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            cbe_pkg::S_IDLE:  n_state = in_xfer ? cbe_pkg::S_SETUP : cbe_pkg::S_IDLE;
            cbe_pkg::S_SETUP: n_state = diag ? cbe_pkg::S_DONE : cbe_pkg::S_M1;
            cbe_pkg::S_M1:    n_state = cbe_pkg::S_A1;
            cbe_pkg::S_A1:    n_state = cbe_pkg::S_M2;
            cbe_pkg::S_M2:    n_state = cbe_pkg::S_A2;
            cbe_pkg::S_A2:    n_state = cbe_pkg::S_M3;
            cbe_pkg::S_M3:    n_state = cbe_pkg::S_A3;
            cbe_pkg::S_A3:    n_state = cbe_pkg::S_UPD;
            cbe_pkg::S_UPD: begin
                if (f_ok || last_step) begin
                    n_state = cbe_pkg::S_F0;
                end else begin
                    n_state = cbe_pkg::S_M1;
                end
            end
            cbe_pkg::S_F0:    n_state = cbe_pkg::S_F1;
            cbe_pkg::S_F1:    n_state = cbe_pkg::S_F2;
            cbe_pkg::S_F2:    n_state = cbe_pkg::S_F3;
            cbe_pkg::S_F3:    n_state = cbe_pkg::S_F4;
            cbe_pkg::S_F4:    n_state = cbe_pkg::S_F5;
            cbe_pkg::S_F5:    n_state = cbe_pkg::S_F6;
            cbe_pkg::S_F6:    n_state = cbe_pkg::S_F7;
            cbe_pkg::S_F7:    n_state = cbe_pkg::S_DONE;
            cbe_pkg::S_DONE:  n_state = out_load ? cbe_pkg::S_IDLE : cbe_pkg::S_DONE;
            default:          n_state = cbe_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cbe_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x_raw   <= s_axis_tdata[FW-1:0];
            r_c1x_raw <= s_axis_tdata[2*FW-1:FW];
            r_c1y_raw <= s_axis_tdata[3*FW-1:2*FW];
            r_c2x_raw <= s_axis_tdata[4*FW-1:3*FW];
            r_c2y_raw <= s_axis_tdata[5*FW-1:4*FW];
        end
        if (out_load) begin
            r_o_y     <= y_out;
            r_o_steps <= steps_out;
            r_o_conv  <= r_conv;
        end
        case (r_state)
            cbe_pkg::S_SETUP: begin
                r_diag  <= diag;
                r_conv  <= diag;
                r_steps <= '0;
                r_x     <= to_int(r_x_raw);
                r_t     <= to_int(r_x_raw);
                r_ay    <= to_int(r_c1y_raw);
                r_by    <= to_int(r_c2y_raw);
                r_k0    <= k0_new;
                r_k1    <= k1_new;
                r_k2    <= k2_new;
            end
            cbe_pkg::S_A1: r_f <= f_add_k1;
            cbe_pkg::S_A2: r_f <= f_add_k2;
            cbe_pkg::S_A3: r_f <= f_sub_x;
            cbe_pkg::S_UPD: begin
                if (f_ok) begin
                    r_conv <= 1'b1;
                end else begin
                    r_t     <= t_upd;
                    r_steps <= steps_inc;
                end
            end
            cbe_pkg::S_F0: begin
                r_r   <= r_new;
                r_t3x <= t3x_new;
            end
            cbe_pkg::S_F1: r_t2 <= w_p;
            cbe_pkg::S_F2: begin
                r_rr <= w_p;
                r_s2 <= s2_new;
            end
            cbe_pkg::S_F3: r_t3 <= w_p;
            cbe_pkg::S_F4: r_v  <= w_p;
            cbe_pkg::S_F5: r_u  <= w_p;
            cbe_pkg::S_F6: r_m1 <= w_p;
            cbe_pkg::S_F7: r_y  <= y_clamp;
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == cbe_pkg::S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{cbe_pkg::OUT_PAD_W{1'b0}}, r_o_steps, r_o_y};
    assign m_axis_tuser  = r_o_conv;

    `CBE_ASSERT_IMPL(a_steps_bound, steps_live, r_steps <= SW'(MAX_ITERATIONS), "step count past limit")
    `CBE_ASSERT_IMPL(a_final_from_upd, r_state == cbe_pkg::S_F0, $past(r_state) == cbe_pkg::S_UPD, "final phase entered outside update")
    `CBE_ASSERT_IMPL(a_noconv_limit, out_load && !r_conv, r_steps == SW'(MAX_ITERATIONS), "unconverged result before limit")
    `CBE_ASSERT_NEXT(a_accept_setup, in_xfer, r_state == cbe_pkg::S_SETUP, "accepted item not set up")

endmodule

// ===== design/cbe_mul_q.sv =====
// Shared fixed-point multiplier: product rounded half up, saturated, registered.
module cbe_mul_q #(
    parameter int FRAC_BITS = cbe_pkg::DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic signed [FRAC_BITS+4:0] i_a,
    input  logic signed [FRAC_BITS+4:0] i_b,
    output logic signed [FRAC_BITS+4:0] o_p
);

    localparam int W    = FRAC_BITS + 5;
    localparam int PW   = 2 * W;
    localparam int HALF = 1 << (FRAC_BITS - 1);

    localparam logic signed [W-1:0] Q_TOP = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Q_BOT = {1'b1, {(W-1){1'b0}}};

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shf;
    logic                 fits;
    logic signed [W-1:0]  n_p;
    logic signed [W-1:0]  r_p;

    always_comb begin
        prod = i_a * i_b;
        rnd  = prod + PW'(HALF);
        shf  = rnd >>> FRAC_BITS;
        // in range when all bits above the sign bit agree with it
        fits = (&shf[PW-1:W-1]) || !(|shf[PW-1:W-1]);
        if (fits) begin
            n_p = shf[W-1:0];
        end else if (shf[PW-1]) begin
            n_p = Q_BOT;
        end else begin
            n_p = Q_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule
